// ===== hdl/crt_controller_register_port_assert.svh =====
// ----------------------------------------------------------------------------
// crt controller register port assertion macros
// shared property forms used by the rtl checks
// ----------------------------------------------------------------------------
`ifndef CRT_CONTROLLER_REGISTER_PORT_ASSERT_SVH
`define CRT_CONTROLLER_REGISTER_PORT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// constants, types and codes of the crt controller register port
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int unsigned WindowPorts = 32;
  localparam int unsigned OfsW        = $clog2(WindowPorts);
  localparam int unsigned LaneW       = 2;

  // window offsets
  localparam logic [OfsW-1:0] OfsIndex = 5'h14;
  localparam logic [OfsW-1:0] OfsData  = 5'h15;
  localparam logic [OfsW-1:0] OfsAlias = 5'h13;

  // crt register indices
  localparam logic [7:0] IxCurStart = 8'h0a;
  localparam logic [7:0] IxCurEnd   = 8'h0b;
  localparam logic [7:0] IxStartHi  = 8'h0c;
  localparam logic [7:0] IxStartLo  = 8'h0d;
  localparam logic [7:0] IxLocHi    = 8'h0e;
  localparam logic [7:0] IxLocLo    = 8'h0f;

  // reset values
  localparam logic [15:0] IoBaseReset      = 16'h03c0;
  localparam logic [15:0] CursorShapeReset = 16'h0d0e;
  localparam logic [15:0] CursorLocReset   = 16'd1920;
  localparam logic [15:0] StartAddrReset   = 16'h0000;
  localparam logic [7:0]  UnknownByte      = 8'hff;

  // access kinds and size codes
  localparam logic       KindWrite = 1'b1;
  localparam logic [1:0] Size1     = 2'd0;
  localparam logic [1:0] Size2     = 2'd1;

  // apb
  localparam int unsigned PaddrW    = 3;
  localparam logic        RegIoBase = 1'b0;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StLane = 3'b010,
    StDone = 3'b100
  } state_e;

  // one byte access handed to the register file
  typedef struct packed {
    logic            en;
    logic            wr;
    logic [OfsW-1:0] ofs;
    logic [7:0]      wdata;
  } lane_acc_t;

  // window decode of one byte lane
  typedef struct packed {
    logic            hit;
    logic [OfsW-1:0] ofs;
  } lane_dec_t;

endpackage

// ===== hdl/crp_req_if.sv =====
// ----------------------------------------------------------------------------
// crp_req_if
// port access channel: one transaction per i/o access
// ----------------------------------------------------------------------------
interface crp_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] port;
  logic [1:0]  size_code;
  logic [31:0] bus_data;

  modport source (output valid, kind, port, size_code, bus_data, input ready);
  modport sink (input valid, kind, port, size_code, bus_data, output ready);
endinterface

// ===== hdl/crp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// crp_rsp_if
// result channel: read data and claim flag per access
// ----------------------------------------------------------------------------
interface crp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        claimed;

  modport source (output valid, read_data, claimed, input ready);
  modport sink (input valid, read_data, claimed, output ready);
endinterface

// ===== hdl/crp_lane_dec.sv =====
// ----------------------------------------------------------------------------
// crp_lane_dec
// shared window decoder: byte port of one lane against the window base
// ----------------------------------------------------------------------------
module crp_lane_dec (
  input  logic [15:0]                    port_i,
  input  logic [crp_pkg::LaneW-1:0]      lane_i,
  input  logic [15:0]                    io_base_i,
  output crp_pkg::lane_dec_t             dec_o
);

  logic [16:0] bport;
  logic [17:0] diff;

  // no wrap past 0xffff, so the byte port keeps a carry bit
  assign bport = {1'b0, port_i} + {15'b0, lane_i};
  assign diff  = {1'b0, bport} - {2'b0, io_base_i};

  assign dec_o.hit = (diff[17:crp_pkg::OfsW] == '0);
  assign dec_o.ofs = diff[crp_pkg::OfsW-1:0];

endmodule

// ===== hdl/crp_regfile.sv =====
// ----------------------------------------------------------------------------
// crp_regfile
// crt index register and the data registers behind it, one byte per cycle
// ----------------------------------------------------------------------------
module crp_regfile (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crp_pkg::lane_acc_t    acc_i,
  output logic [7:0]            rdata_o
);

  logic [7:0]  crt_index_q, crt_index_d;
  logic [15:0] cursor_shape_q, cursor_shape_d;
  logic [15:0] cursor_location_q, cursor_location_d;
  logic [15:0] start_address_q, start_address_d;
  logic [7:0]  data_rd;

  always_comb begin
    case (crt_index_q)
      crp_pkg::IxCurStart: data_rd = cursor_shape_q[15:8];
      crp_pkg::IxCurEnd:   data_rd = cursor_shape_q[7:0];
      crp_pkg::IxLocHi:    data_rd = cursor_location_q[15:8];
      crp_pkg::IxLocLo:    data_rd = cursor_location_q[7:0];
      crp_pkg::IxStartHi:  data_rd = start_address_q[15:8];
      crp_pkg::IxStartLo:  data_rd = start_address_q[7:0];
      default:             data_rd = crp_pkg::UnknownByte;
    endcase
  end

  always_comb begin
    case (acc_i.ofs)
      crp_pkg::OfsIndex: rdata_o = crt_index_q;
      crp_pkg::OfsData:  rdata_o = data_rd;
      crp_pkg::OfsAlias: rdata_o = data_rd;
      default:           rdata_o = crp_pkg::UnknownByte;
    endcase
  end

  always_comb begin
    crt_index_d       = crt_index_q;
    cursor_shape_d    = cursor_shape_q;
    cursor_location_d = cursor_location_q;
    start_address_d   = start_address_q;
    if (acc_i.en && acc_i.wr) begin
      if (acc_i.ofs == crp_pkg::OfsIndex) begin
        crt_index_d = acc_i.wdata;
      end else if (acc_i.ofs == crp_pkg::OfsData) begin
        case (crt_index_q)
          crp_pkg::IxCurStart: cursor_shape_d[15:8]    = acc_i.wdata;
          crp_pkg::IxCurEnd:   cursor_shape_d[7:0]     = acc_i.wdata;
          crp_pkg::IxLocHi:    cursor_location_d[15:8] = acc_i.wdata;
          crp_pkg::IxLocLo:    cursor_location_d[7:0]  = acc_i.wdata;
          crp_pkg::IxStartHi:  start_address_d[15:8]   = acc_i.wdata;
          crp_pkg::IxStartLo:  start_address_d[7:0]    = acc_i.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crt_index_q       <= '0;
      cursor_shape_q    <= crp_pkg::CursorShapeReset;
      cursor_location_q <= crp_pkg::CursorLocReset;
      start_address_q   <= crp_pkg::StartAddrReset;
    end else begin
      crt_index_q       <= crt_index_d;
      cursor_shape_q    <= cursor_shape_d;
      cursor_location_q <= cursor_location_d;
      start_address_q   <= start_address_d;
    end
  end

endmodule

// ===== hdl/crt_controller_register_port.sv =====
// ----------------------------------------------------------------------------
// crt_controller_register_port
// vga crt controller index/data register pair behind an i/o port window
// ----------------------------------------------------------------------------
// usage:
//   req_i carries one i/o access per transaction (kind, port, size_code,
//   bus_data); rsp_o returns one transaction per access with read_data and
//   claimed. io_base is set through the apb port at byte address 0.
//   the access bytes go one per cycle through a shared window decoder and
//   the register file, lowest port first, one lane per byte of the access.
//   the result is held in the output register while the done state lasts,
//   and the next access is accepted only after the result has been taken.
//   req_i.ready is high only while idle. a stalled receiver holds the result
//   in the output register and the block takes no new access meanwhile.
//   reset clears the sequencer, sets io_base to 0x3c0, crt index to 0,
//   cursor shape to 0x0d0e, cursor location to 1920 and start address to 0.
// ----------------------------------------------------------------------------
module crt_controller_register_port (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  crp_req_if.sink                     req_i,
  crp_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crp_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  `include "crt_controller_register_port_assert.svh"

  crp_pkg::state_e             state_q, state_d;
  logic [crp_pkg::LaneW-1:0]   lane_q, lane_d;
  logic [crp_pkg::LaneW-1:0]   last_q, last_d;
  logic                        kind_q;
  logic [15:0]                 port_q;
  logic [31:0]                 data_q, data_d;
  logic [31:0]                 wdata_q;
  logic                        hit_q, hit_d;
  logic [31:0]                 rsp_data_q, rsp_data_d;
  logic [15:0]                 io_base_q;
  logic                        req_acc;
  logic                        cfg_wr;
  crp_pkg::lane_dec_t          dec;
  crp_pkg::lane_acc_t          acc;
  logic [7:0]                  rd_byte;

  // apb configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == crp_pkg::RegIoBase);
  assign prdata = (paddr[2] == crp_pkg::RegIoBase) ? {16'b0, io_base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_base_q <= crp_pkg::IoBaseReset;
    end else if (cfg_wr) begin
      io_base_q <= pwdata[15:0];
    end
  end

  crp_lane_dec u_lane_dec (
    .port_i    (port_q),
    .lane_i    (lane_q),
    .io_base_i (io_base_q),
    .dec_o     (dec)
  );

  assign acc.en    = (state_q == crp_pkg::StLane) && dec.hit;
  assign acc.wr    = (kind_q == crp_pkg::KindWrite);
  assign acc.ofs   = dec.ofs;
  assign acc.wdata = wdata_q[lane_q*8 +: 8];

  crp_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .rdata_o (rd_byte)
  );

  assign req_acc      = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == crp_pkg::StIdle);
  assign rsp_o.valid  = (state_q == crp_pkg::StDone);
  assign rsp_o.read_data = rsp_data_q;
  assign rsp_o.claimed   = hit_q;

  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    last_d     = last_q;
    data_d     = data_q;
    hit_d      = hit_q;
    rsp_data_d = rsp_data_q;
    case (state_q)
      crp_pkg::StIdle: begin
        if (req_acc) begin
          state_d = crp_pkg::StLane;
          lane_d  = '0;
          hit_d   = 1'b0;
          data_d  = req_i.bus_data;
          case (req_i.size_code)
            crp_pkg::Size1: last_d = 2'd0;
            crp_pkg::Size2: last_d = 2'd1;
            default:        last_d = 2'd3;
          endcase
        end
      end
      crp_pkg::StLane: begin
        if (dec.hit) begin
          hit_d = 1'b1;
          if (kind_q != crp_pkg::KindWrite) begin
            data_d[lane_q*8 +: 8] = rd_byte;
          end
        end
        if (lane_q == last_q) begin
          state_d = crp_pkg::StDone;
          if (kind_q == crp_pkg::KindWrite) begin
            rsp_data_d = '0;
          end else begin
            rsp_data_d = data_d;
          end
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      crp_pkg::StDone: begin
        if (rsp_o.ready) begin
          state_d = crp_pkg::StIdle;
        end
      end
      default: state_d = crp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crp_pkg::StIdle;
      lane_q  <= '0;
      last_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      last_q  <= last_d;
      hit_q   <= hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q  <= req_i.kind;
      port_q  <= req_i.port;
      wdata_q <= req_i.bus_data;
    end
    data_q     <= data_d;
    rsp_data_q <= rsp_data_d;
  end

  `CRP_ASSERT_NXT(a_accept_starts_lanes, clk_i, rst_ni, req_acc, state_q == crp_pkg::StLane, "accepted transaction did not start lane processing")
  `CRP_ASSERT_IMP(a_lane_in_range, clk_i, rst_ni, state_q == crp_pkg::StLane, lane_q <= last_q, "lane counter ran past the last byte of the access")
  `CRP_ASSERT_IMP(a_write_reads_zero, clk_i, rst_ni, rsp_o.valid && (kind_q == crp_pkg::KindWrite), rsp_o.read_data == '0, "write transaction returned nonzero read data")
  `CRP_ASSERT_NXT(a_stall_holds_result, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_data_q) && $stable(hit_q), "stalled result changed")

endmodule
